// ----- hw/rtl/u8d_pkg.sv -----
`default_nettype none

package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned NeedW = 2;

  localparam logic [CpW-1:0]   Replacement = 21'h00FFFD;
  localparam logic [ByteW-1:0] ContMask    = 8'h3F;
  localparam logic [ByteW-1:0] Lead2Mask   = 8'h1F;
  localparam logic [ByteW-1:0] Lead3Mask   = 8'h0F;
  localparam logic [ByteW-1:0] Lead4Mask   = 8'h07;

  // Lead byte ranges
  localparam logic [ByteW-1:0] AsciiLast  = 8'h7F;
  localparam logic [ByteW-1:0] Lead2First = 8'hC0;
  localparam logic [ByteW-1:0] Lead2Last  = 8'hDF;
  localparam logic [ByteW-1:0] Lead3First = 8'hE0;
  localparam logic [ByteW-1:0] Lead3Last  = 8'hEF;
  localparam logic [ByteW-1:0] Lead4First = 8'hF0;
  localparam logic [ByteW-1:0] Lead4Last  = 8'hF7;

  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             final_byte;
  } u8d_in_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           end_of_text;
  } u8d_out_t;

  // Decoder status toward the pipeline control
  typedef struct packed {
    logic     has_result;
    u8d_out_t item;
  } u8d_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/u8d_in_stage.sv -----
`default_nettype none

module u8d_in_stage
  import u8d_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire u8d_in_t in_item_i,
  input  wire logic    take_i,
  output logic         valid_o,
  output u8d_in_t      item_o
);

  logic    valid_q, valid_d;
  u8d_in_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ----- hw/rtl/u8d_decode.sv -----
`default_nettype none

module u8d_decode
  import u8d_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,
  input  wire u8d_in_t item_i,
  output u8d_res_t     res_o
);

  logic [NeedW-1:0] need_q, need_d;
  logic [CpW-1:0]   acc_q, acc_d;
  logic [CpW-1:0]   acc_shift;
  logic [NeedW-1:0] need_dec;
  logic [ByteW-1:0] b;
  logic             last;

  assign b         = item_i.text_byte;
  assign last      = item_i.final_byte;
  assign acc_shift = {acc_q[CpW-7:0], b[5:0] & ContMask[5:0]};
  assign need_dec  = need_q - NeedW'(1);

  always_comb begin
    need_d     = need_q;
    acc_d      = acc_q;
    res_o      = '0;
    res_o.item.end_of_text = last;
    if (need_q == '0) begin
      if (b inside {[8'h00:AsciiLast]}) begin
        res_o.has_result      = 1'b1;
        res_o.item.code_point = CpW'(b);
      end else if (b inside {[Lead2First:Lead2Last]}) begin
        need_d = NeedW'(1);
        acc_d  = CpW'(b & Lead2Mask);
      end else if (b inside {[Lead3First:Lead3Last]}) begin
        need_d = NeedW'(2);
        acc_d  = CpW'(b & Lead3Mask);
      end else if (b inside {[Lead4First:Lead4Last]}) begin
        need_d = NeedW'(3);
        acc_d  = CpW'(b & Lead4Mask);
      end else begin
        // stray continuation or F8..FF
        res_o.has_result      = 1'b1;
        res_o.item.code_point = Replacement;
      end
      if (need_d != '0 && last) begin
        // lead byte cut off by end of text
        need_d                = '0;
        acc_d                 = '0;
        res_o.has_result      = 1'b1;
        res_o.item.code_point = Replacement;
      end
    end else begin
      // any byte counts as a continuation here
      need_d = need_dec;
      acc_d  = acc_shift;
      if (need_dec == '0) begin
        acc_d                 = '0;
        res_o.has_result      = 1'b1;
        res_o.item.code_point = acc_shift;
      end else if (last) begin
        need_d                = '0;
        acc_d                 = '0;
        res_o.has_result      = 1'b1;
        res_o.item.code_point = Replacement;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= '0;
      acc_q  <= '0;
    end else if (step_i) begin
      need_q <= need_d;
      acc_q  <= acc_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/u8d_out_stage.sv -----
`default_nettype none

module u8d_out_stage
  import u8d_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire u8d_out_t item_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output u8d_out_t      out_item_o
);

  logic     valid_q, valid_d;
  u8d_out_t item_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

// ----- hw/rtl/utf8_byte_stream_decoder.sv -----
`default_nettype none

// UTF-8 byte stream decoder. One text byte per input transfer, with
// final_byte marking the last byte of a text; one code point per output
// transfer when a character completes. Lead bytes 110x, 1110x and 11110x
// open 2, 3 and 4 byte sequences; following bytes are taken as
// continuations with no check of their top bits. A stray continuation or a
// byte F8..FF gives U+FFFD, as does a sequence cut off by the final byte
// (one U+FFFD, end_of_text set). Overlong forms and surrogates pass as
// decoded. A byte passes through the input register, then the decode, then
// the result register that drives the output; a byte is accepted
// every cycle as long as the output side keeps up. The decode state (bytes
// still needed, partial code point) updates once per byte taken, which
// sets the one byte per cycle rate. Bytes that close no character take no
// output slot, so they still move while the output is stalled if the input
// register can drain.
module utf8_byte_stream_decoder
  import u8d_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire u8d_in_t in_item_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output u8d_out_t     out_item_o
);

  logic     stg_valid;
  u8d_in_t  stg_item;
  logic     stg_take;
  u8d_res_t dec_res;
  logic     out_free;

  // Input register
  u8d_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .take_i     (stg_take),
    .valid_o    (stg_valid),
    .item_o     (stg_item)
  );

  // Byte leaves the input register once its result (if any) has a slot
  assign stg_take = stg_valid && (!dec_res.has_result || out_free);

  // Sequence state and decode
  u8d_decode u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (stg_take),
    .item_i (stg_item),
    .res_o  (dec_res)
  );

  // Result register
  u8d_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (stg_take && dec_res.has_result),
    .item_i      (dec_res.item),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb_utf8_byte_stream_decoder.sv -----
`default_nettype none

// Self-checking bench for the UTF-8 byte stream decoder.
// An initial block builds the whole byte stream up front: a short directed
// list, then random texts made mostly of well-formed characters with random
// payload bits, some noise bytes and some texts cut off mid-sequence. A
// clocked driver feeds the stream to the input channel. A clocked monitor
// checks each output transfer against the oldest predicted code point and
// predicts the result of each accepted input byte. A separate receiver
// process drives out_ready, with random stalls and one long hold-off.
module tb_utf8_byte_stream_decoder
  import u8d_pkg::*;
();

  localparam int CycleLimit = 400_000;
  localparam int RandBytes  = 2000;
  localparam int HoldAt     = 400;      // results seen before the long hold-off
  localparam int HoldCycles = 300;
  localparam int DrainWait  = 20;
  localparam int Segment    = 150;      // length of an idling pattern stretch

  typedef struct {
    u8d_in_t item;
    int      gap;  // idle cycles before this byte is offered
  } queued_byte_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  u8d_in_t  in_item = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  u8d_out_t out_item;

  // Stimulus and expectation stores
  queued_byte_t byte_queue[$];
  u8d_out_t     pending_cps[$];

  // Predictor state: continuation bytes still owed and partial code point
  logic [NeedW-1:0] need_cnt = '0;
  logic [CpW-1:0]   acc_cp = '0;

  int total_bytes = 0;   // bytes queued by the initial block
  int bytes_in = 0;      // input transfers seen
  int cps_checked = 0;
  int fffd_seen = 0;
  int texts_ended = 0;
  int cut_texts = 0;
  int err_count = 0;
  int send_wait = 0;
  int stall_left = 0;
  int rx_seen = 0;
  int cycle_count = 0;

  utf8_byte_stream_decoder uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #10 clk = ~clk;

  // Decode one byte into the predictor state; emit says a code point is due.
  function automatic void decode_byte(input u8d_in_t xfer, output logic emit,
                                      output u8d_out_t res);
    logic [ByteW-1:0] b;
    logic             opened;
    b      = xfer.text_byte;
    emit   = 1'b0;
    opened = 1'b0;
    res    = '0;
    if (need_cnt == '0) begin
      if (b <= AsciiLast) begin
        emit = 1'b1;
        res.code_point = CpW'(b);
      end else if (b >= Lead2First && b <= Lead2Last) begin
        need_cnt = NeedW'(1);
        acc_cp   = CpW'(b & Lead2Mask);
        opened   = 1'b1;
      end else if (b >= Lead3First && b <= Lead3Last) begin
        need_cnt = NeedW'(2);
        acc_cp   = CpW'(b & Lead3Mask);
        opened   = 1'b1;
      end else if (b >= Lead4First && b <= Lead4Last) begin
        need_cnt = NeedW'(3);
        acc_cp   = CpW'(b & Lead4Mask);
        opened   = 1'b1;
      end else begin
        // stray continuation or F8..FF
        emit = 1'b1;
        res.code_point = Replacement;
      end
      res.end_of_text = xfer.final_byte;
      // a lead byte that ends the text is a cut-off sequence
      if (opened && xfer.final_byte) begin
        need_cnt        = '0;
        acc_cp          = '0;
        emit            = 1'b1;
        res.code_point  = Replacement;
        res.end_of_text = 1'b1;
      end
    end else begin
      // top bits of a continuation are not checked
      acc_cp   = (acc_cp << 6) | CpW'(b & ContMask);
      need_cnt = need_cnt - NeedW'(1);
      if (need_cnt == '0) begin
        emit            = 1'b1;
        res.code_point  = acc_cp;
        res.end_of_text = xfer.final_byte;
        acc_cp          = '0;
      end else if (xfer.final_byte) begin
        need_cnt        = '0;
        acc_cp          = '0;
        emit            = 1'b1;
        res.code_point  = Replacement;
        res.end_of_text = 1'b1;
      end
    end
  endfunction

  // Queue one byte; every third stretch of the stream runs with no gaps.
  task automatic push_byte(input logic [ByteW-1:0] b, input logic last);
    queued_byte_t q;
    q.item.text_byte  = b;
    q.item.final_byte = last;
    q.gap = (((total_bytes / Segment) % 3) == 1) ? 0 : $urandom_range(0, 13);
    byte_queue.insert(byte_queue.size(), q);
    total_bytes++;
  endtask

  // One random text: mostly well-formed characters, some noise, some cut off.
  task automatic add_text();
    logic [ByteW-1:0] txt[$];
    int nchar;
    int kind;
    int nb;
    int c;
    int k;
    nchar = $urandom_range(1, 12);
    nb    = 0;
    for (c = 0; c < nchar; c++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        txt.insert(txt.size(), {1'b0, 7'($urandom)});
        nb = 1;
      end else if (kind < 55) begin
        txt.insert(txt.size(), {3'b110, 5'($urandom)});
        nb = 2;
      end else if (kind < 72) begin
        txt.insert(txt.size(), {4'b1110, 4'($urandom)});
        nb = 3;
      end else if (kind < 88) begin
        txt.insert(txt.size(), {5'b11110, 3'($urandom)});
        nb = 4;
      end else begin
        // noise: any byte, lead or not
        txt.insert(txt.size(), 8'($urandom));
        nb = 1;
      end
      for (k = 1; k < nb; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          txt.insert(txt.size(), 8'($urandom));  // malformed continuation
        end else begin
          txt.insert(txt.size(), {2'b10, 6'($urandom)});
        end
      end
    end
    if (nb > 1 && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, nb - 1)) void'(txt.pop_back());
      cut_texts++;
    end
    for (k = 0; k < txt.size(); k++) begin
      push_byte(txt[k], k == txt.size() - 1);
    end
  endtask

  // Driver: offers the next byte once the channel is free and its gap is over.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (byte_queue.size() != 0 && send_wait >= byte_queue[0].gap) begin
          in_item  <= byte_queue[0].item;
          in_valid <= 1'b1;
          void'(byte_queue.pop_front());
          send_wait = 0;
        end else begin
          in_valid <= 1'b0;
          if (byte_queue.size() != 0) begin
            send_wait++;
          end
        end
      end
    end
  end

  // Receiver: stall after each transfer, one stretch with no stalls in
  // three, and one long hold-off so the block backs up into its input.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        rx_seen++;
        if (rx_seen == HoldAt) begin
          stall_left = HoldCycles;
        end else if (((rx_seen / Segment) % 3) == 2) begin
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 13);
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: check output transfers first, then predict the accepted byte.
  // The block registers its result, so a byte accepted at this edge can not
  // produce the transfer seen at the same edge.
  always @(posedge clk) begin : monitor
    u8d_out_t want;
    u8d_out_t res;
    logic     got_one;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_cps.size() == 0) begin
          $display("%0t: unexpected transfer: expected none, actual cp %06h eot %0b",
                   $time, out_item.code_point, out_item.end_of_text);
          err_count++;
        end else begin
          want = pending_cps.pop_front();
          if (out_item.code_point !== want.code_point) begin
            $display("%0t: code_point mismatch: expected %06h, actual %06h",
                     $time, want.code_point, out_item.code_point);
            err_count++;
          end
          if (out_item.end_of_text !== want.end_of_text) begin
            $display("%0t: end_of_text mismatch: expected %0b, actual %0b",
                     $time, want.end_of_text, out_item.end_of_text);
            err_count++;
          end
          if (want.code_point == Replacement) fffd_seen++;
          if (want.end_of_text) texts_ended++;
        end
        cps_checked++;
      end
      if (in_valid && in_ready) begin
        decode_byte(in_item, got_one, res);
        if (got_one) pending_cps.insert(pending_cps.size(), res);
        bytes_in++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    // Directed: ASCII extremes, overlong and surrogate forms, the largest
    // 4-byte value, stray bytes, an unchecked continuation and cut-offs.
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hC0, 1'b0);  // overlong NUL
    push_byte(8'h80, 1'b0);
    push_byte(8'hE2, 1'b0);  // euro sign
    push_byte(8'h82, 1'b0);
    push_byte(8'hAC, 1'b0);
    push_byte(8'hED, 1'b0);  // surrogate D800
    push_byte(8'hA0, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);  // stray continuation
    push_byte(8'hF8, 1'b0);  // invalid lead
    push_byte(8'hC3, 1'b0);  // ASCII taken as continuation
    push_byte(8'h41, 1'b0);
    push_byte(8'hF7, 1'b0);  // largest 4-byte value, ends a text
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b1);
    push_byte(8'hE2, 1'b0);  // 3-byte cut after one continuation
    push_byte(8'h82, 1'b1);
    push_byte(8'hC3, 1'b1);  // lead byte as the last byte
    push_byte(8'hF0, 1'b0);  // 4-byte cut after one continuation
    push_byte(8'h9F, 1'b1);
    push_byte(8'hFF, 1'b1);  // stray byte ending a text
    push_byte(8'h7F, 1'b1);  // ASCII ending a text
    while (total_bytes < RandBytes) add_text();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_in != total_bytes || pending_cps.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("tb: %0d bytes sent, %0d code points checked, %0d of them U+FFFD",
             bytes_in, cps_checked, fffd_seen);
    $display("tb: %0d texts ended, %0d cut off mid-sequence, one %0d-cycle output hold-off",
             texts_ended, cut_texts, HoldCycles);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_in_stage.sv
hw/rtl/u8d_decode.sv
hw/rtl/u8d_out_stage.sv
hw/rtl/utf8_byte_stream_decoder.sv
tb/tb_utf8_byte_stream_decoder.sv
